// File: rtl/core/diff_drive_odometry_defines.svh
// ----------------------------------------------------------------------------
// diff_drive_odometry_defines.svh
// Assertion macros used by the odometry controller (ddo_ctrl).
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DDO_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DDO_ASSERT_IMPL(label, ante, cons, msg)

`define DDO_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and fixed constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

   // field widths
   localparam int COUNT_W        = 32;
   localparam int POSE_W         = 32;
   localparam int HEADING_W      = 16;
   localparam int CFG_W          = 32;
   localparam int CSR_INDEX_BITS = 4;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_METERS_PER_TICK  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADING_PER_TICK = CSR_INDEX_BITS'(1);

   localparam logic [CFG_W-1:0] METERS_PER_TICK_RESET  = 32'd2617267;
   localparam logic [CFG_W-1:0] HEADING_PER_TICK_RESET = 32'd1639973;

   // cordic
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam int CORDIC_W     = 32;
   localparam int ANGLE24_W    = 24;
   localparam int Z_W          = 25;
   localparam int ATAN_W       = 22;
   localparam int TRIG_W       = 16;

   localparam logic signed [CORDIC_W-1:0] CORDIC_X0    = 32'sd652032874;
   localparam logic signed [CORDIC_W-1:0] CORDIC_ROUND = 32'sd16384;
   localparam logic signed [CORDIC_W-1:0] Q15_MAX      = 32'sd32767;
   localparam logic signed [CORDIC_W-1:0] Q15_MIN      = -32'sd32768;
   localparam logic signed [TRIG_W-1:0]   TRIG_MAX     = 16'sh7fff;
   localparam logic signed [TRIG_W-1:0]   TRIG_MIN     = 16'sh8000;

   localparam logic signed [Z_W-1:0] ANG_QUARTER     = 25'sd4194304;
   localparam logic signed [Z_W-1:0] ANG_NEG_QUARTER = -25'sd4194304;
   localparam logic signed [Z_W-1:0] ANG_HALF        = 25'sd8388608;

   // arctangent of 2^-i in 24-bit turns
   localparam logic [ATAN_W-1:0] ATAN_TURN24 [CORDIC_ITERS] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
      22'd166669,  22'd83416,   22'd41718,  22'd20860,
      22'd10430,   22'd5215,    22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81
   };

   // distance and pose
   localparam int DIST_W  = 48;
   localparam logic [DIST_W-1:0] DIST_LIMIT = 48'h8000_0000_0000;
   localparam int Q15_SHIFT = 15;
   localparam int STEP_ROUND = 16384;
   localparam int HEADING_ROUND = 32768;
   localparam int TURN_FRAC = 16;

   localparam logic signed [POSE_W-1:0] POSE_MAX = 32'sh7fff_ffff;
   localparam logic signed [POSE_W-1:0] POSE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic load;
      logic cordic_step;
      logic finish;
      logic scale_x;
      logic scale_y;
      logic commit;
   } ddo_cmd_type;

   typedef struct packed {
      logic cordic_last;
   } ddo_status_type;

endpackage

// File: rtl/core/ddo_req_if.sv
// ----------------------------------------------------------------------------
// ddo_req_if
// Encoder count channel: valid, ready and one pair of absolute counts.
// ----------------------------------------------------------------------------
interface ddo_req_if import ddo_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] left_count;
   logic signed [COUNT_W-1:0] right_count;

   modport source (output valid, output left_count, output right_count, input ready);
   modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

// File: rtl/core/ddo_rsp_if.sv
// ----------------------------------------------------------------------------
// ddo_rsp_if
// Pose channel: valid, ready, position, heading and saturation flag.
// ----------------------------------------------------------------------------
interface ddo_rsp_if import ddo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POSE_W-1:0] pose_x;
   logic signed [POSE_W-1:0] pose_y;
   logic [HEADING_W-1:0]     heading;
   logic                     saturated;

   modport source (output valid, output pose_x, output pose_y, output heading,
                   output saturated, input ready);
   modport sink   (input valid, input pose_x, input pose_y, input heading,
                   input saturated, output ready);
endinterface

// File: rtl/core/ddo_csr_if.sv
// ----------------------------------------------------------------------------
// ddo_csr_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface ddo_csr_if import ddo_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_W-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Update sequencer: accepts a beat, steps the cordic, scales and commits.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_defines.svh"

module ddo_ctrl
   import ddo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output ddo_cmd_type    cmd,
   input  ddo_status_type status
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CORDIC  = 6'b000010,
      S_FINISH  = 6'b000100,
      S_SCALE_X = 6'b001000,
      S_SCALE_Y = 6'b010000,
      S_COMMIT  = 6'b100000
   } ddo_state_type;

   ddo_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_SCALE_X;
         end
         S_SCALE_X: begin
            cmd.scale_x = 1'b1;
            state_in    = S_SCALE_Y;
         end
         S_SCALE_Y: begin
            cmd.scale_y = 1'b1;
            state_in    = S_COMMIT;
         end
         S_COMMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `DDO_ASSERT_IMPL(a_commit_slot, cmd.commit, (!out_valid_ff || rsp_ready), "commit over a pending beat")
   `DDO_ASSERT_NEXT(a_load_to_cordic, cmd.load, (state_ff == S_CORDIC), "load did not start cordic")
   `DDO_ASSERT_IMPL(a_rsp_after_commit, $rose(out_valid_ff), $past(cmd.commit), "result without commit")

endmodule

// File: rtl/core/ddo_dpath.sv
// ----------------------------------------------------------------------------
// ddo_dpath
// Odometry datapath: deltas, distance scaling, cordic, pose and heading update.
// ----------------------------------------------------------------------------
module ddo_dpath
   import ddo_pkg::*;
#(
   parameter int COUNT_BITS     = 32,
   parameter int ANGLE_BITS     = 16,
   parameter int POSE_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ddo_cmd_type               cmd,
   output ddo_status_type            status,
   input  logic signed [COUNT_W-1:0] left_count,
   input  logic signed [COUNT_W-1:0] right_count,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_W-1:0]          csr_data,
   output logic signed [POSE_W-1:0]  pose_x,
   output logic signed [POSE_W-1:0]  pose_y,
   output logic [HEADING_W-1:0]      heading,
   output logic                      saturated
);

   localparam int MAG_W   = COUNT_BITS + 1;
   localparam int DPROD_W = COUNT_BITS + CFG_W;
   localparam int RND_W   = DPROD_W + 1;
   localparam int DIST_SH = 33 - POSE_FRAC_BITS;
   localparam int TURN_W  = ANGLE_BITS + TURN_FRAC;
   localparam int SPROD_W = DIST_W + TRIG_W;
   localparam int SUM_W   = DIST_W + 2;
   localparam int ANG_SH  = ANGLE24_W - ANGLE_BITS;

   localparam logic [RND_W-1:0] DIST_HALF = RND_W'(1) << (DIST_SH - 1);

   function automatic logic signed [TRIG_W-1:0] clamp_q15(
      input logic signed [CORDIC_W-1:0] v
   );
      logic signed [TRIG_W-1:0] r;
      if (v > Q15_MAX) begin
         r = TRIG_MAX;
      end else if (v < Q15_MIN) begin
         r = TRIG_MIN;
      end else begin
         r = v[TRIG_W-1:0];
      end
      return r;
   endfunction

   // returns {clipped, new position}
   function automatic logic [POSE_W:0] add_sat(
      input logic signed [POSE_W-1:0] base,
      input logic [SPROD_W-1:0]       prod,
      input logic                     neg
   );
      logic [SPROD_W-1:0]      rounded;
      logic signed [SUM_W-1:0] step;
      logic signed [SUM_W-1:0] total;
      logic [POSE_W:0]         r;
      rounded = (prod + SPROD_W'(STEP_ROUND)) >> Q15_SHIFT;
      step    = $signed(SUM_W'(rounded[DIST_W-1:0]));
      if (neg) begin
         step = -step;
      end
      total = SUM_W'(base) + step;
      if (total > SUM_W'(POSE_MAX)) begin
         r = {1'b1, POSE_MAX};
      end else if (total < SUM_W'(POSE_MIN)) begin
         r = {1'b1, POSE_MIN};
      end else begin
         r = {1'b0, total[POSE_W-1:0]};
      end
      return r;
   endfunction

   // configuration
   logic [CFG_W-1:0] mpt_ff, mpt_in, hpt_ff, hpt_in;

   // counts and deltas
   logic [COUNT_BITS-1:0]   prev_left_ff, prev_left_in, prev_right_ff, prev_right_in;
   logic [COUNT_BITS-1:0]   dl_ff, dl_in, dr_ff, dr_in;
   logic signed [MAG_W-1:0] sum_ff, sum_in, diff_ff, diff_in;

   // distance pipeline
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               mag_neg_ff, mag_neg_in;
   logic [DPROD_W-1:0] dprod_ff, dprod_in;
   logic               prod_neg_ff, prod_neg_in;
   logic [RND_W-1:0]   drnd;
   logic [DIST_W-1:0]  dist_mag_ff, dist_mag_in;
   logic               dist_neg_ff, dist_neg_in;

   // heading
   logic [TURN_W-1:0]     hprod_ff, hprod_in, turn_sum;
   logic [ANGLE_BITS-1:0] yaw_ff, yaw_in;

   // cordic
   logic [ANGLE24_W-1:0]       angle24;
   logic signed [Z_W-1:0]      ang_full, ang_fold, atan_z;
   logic                       fold_flip;
   logic signed [CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in, dx, dy;
   logic signed [Z_W-1:0]      cz_ff, cz_in;
   logic                       flip_ff, flip_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic signed [CORDIC_W-1:0] xr, yr, xs, ys;
   logic signed [TRIG_W-1:0]   cos_ff, cos_in, sin_ff, sin_in;

   // scaling and pose
   logic signed [TRIG_W-1:0] trig_sel;
   logic [TRIG_W-1:0]        trig_mag;
   logic [SPROD_W-1:0]       sprod;
   logic [SPROD_W-1:0]       px_ff, px_in, py_ff, py_in;
   logic                     px_neg_ff, px_neg_in, py_neg_ff, py_neg_in;
   logic [POSE_W:0]          sat_x, sat_y;
   logic signed [POSE_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                     sat_ff, sat_in;

   // configuration writes
   always_comb begin
      mpt_in = mpt_ff;
      hpt_in = hpt_ff;
      if (csr_write && (csr_index == CSR_METERS_PER_TICK)) begin
         mpt_in = csr_data;
      end
      if (csr_write && (csr_index == CSR_HEADING_PER_TICK)) begin
         hpt_in = csr_data;
      end
   end

   // deltas and distance pipeline, settled well before scaling
   always_comb begin
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      dl_in         = dl_ff;
      dr_in         = dr_ff;
      if (cmd.load) begin
         prev_left_in  = left_count[COUNT_BITS-1:0];
         prev_right_in = right_count[COUNT_BITS-1:0];
         dl_in         = left_count[COUNT_BITS-1:0] - prev_left_ff;
         dr_in         = right_count[COUNT_BITS-1:0] - prev_right_ff;
      end
      sum_in      = MAG_W'($signed(dl_ff)) + MAG_W'($signed(dr_ff));
      diff_in     = MAG_W'($signed(dr_ff)) - MAG_W'($signed(dl_ff));
      mag_neg_in  = sum_ff[COUNT_BITS];
      mag_in      = sum_ff[COUNT_BITS] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      prod_neg_in = mag_neg_ff;
      dprod_in    = mag_ff[COUNT_BITS] ? {mpt_ff, {COUNT_BITS{1'b0}}}
                                       : DPROD_W'(mag_ff[COUNT_BITS-1:0]) * DPROD_W'(mpt_ff);
      drnd        = (RND_W'(dprod_ff) + DIST_HALF) >> DIST_SH;
      dist_neg_in = prod_neg_ff;
      dist_mag_in = (drnd > RND_W'(DIST_LIMIT)) ? DIST_LIMIT : drnd[DIST_W-1:0];
      hprod_in    = TURN_W'(diff_ff) * TURN_W'(hpt_ff);
   end

   // cordic rotation on the heading held before the step
   always_comb begin
      angle24   = ANGLE24_W'(yaw_ff) << ANG_SH;
      ang_full  = Z_W'($signed(angle24));
      fold_flip = 1'b0;
      ang_fold  = ang_full;
      if (ang_full > ANG_QUARTER) begin
         ang_fold  = ang_full - ANG_HALF;
         fold_flip = 1'b1;
      end else if (ang_full < ANG_NEG_QUARTER) begin
         ang_fold  = ang_full + ANG_HALF;
         fold_flip = 1'b1;
      end

      dx     = cy_ff >>> iter_ff;
      dy     = cx_ff >>> iter_ff;
      atan_z = $signed(Z_W'(ATAN_TURN24[iter_ff]));

      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      if (cmd.load) begin
         cx_in   = CORDIC_X0;
         cy_in   = '0;
         cz_in   = ang_fold;
         flip_in = fold_flip;
         iter_in = '0;
      end else if (cmd.cordic_step) begin
         iter_in = iter_ff + ITER_W'(1);
         if (!cz_ff[Z_W-1]) begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            cz_in = cz_ff - atan_z;
         end else begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            cz_in = cz_ff + atan_z;
         end
      end

      xr     = (cx_ff + CORDIC_ROUND) >>> Q15_SHIFT;
      yr     = (cy_ff + CORDIC_ROUND) >>> Q15_SHIFT;
      xs     = flip_ff ? -xr : xr;
      ys     = flip_ff ? -yr : yr;
      cos_in = cmd.finish ? clamp_q15(xs) : cos_ff;
      sin_in = cmd.finish ? clamp_q15(ys) : sin_ff;
   end

   assign status.cordic_last = (iter_ff == ITER_W'(CORDIC_ITERS - 1));

   // shared magnitude multiplier for both axes
   always_comb begin
      trig_sel  = cmd.scale_y ? sin_ff : cos_ff;
      trig_mag  = trig_sel[TRIG_W-1] ? TRIG_W'(-trig_sel) : TRIG_W'(trig_sel);
      sprod     = SPROD_W'(dist_mag_ff) * SPROD_W'(trig_mag);
      px_in     = cmd.scale_x ? sprod : px_ff;
      px_neg_in = cmd.scale_x ? (dist_neg_ff ^ trig_sel[TRIG_W-1]) : px_neg_ff;
      py_in     = cmd.scale_y ? sprod : py_ff;
      py_neg_in = cmd.scale_y ? (dist_neg_ff ^ trig_sel[TRIG_W-1]) : py_neg_ff;
   end

   // pose commit
   always_comb begin
      sat_x    = add_sat(pos_x_ff, px_ff, px_neg_ff);
      sat_y    = add_sat(pos_y_ff, py_ff, py_neg_ff);
      turn_sum = hprod_ff + TURN_W'(HEADING_ROUND);
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      sat_in   = sat_ff;
      yaw_in   = yaw_ff;
      if (cmd.commit) begin
         pos_x_in = $signed(sat_x[POSE_W-1:0]);
         pos_y_in = $signed(sat_y[POSE_W-1:0]);
         sat_in   = sat_x[POSE_W] | sat_y[POSE_W];
         yaw_in   = yaw_ff + turn_sum[TURN_W-1:TURN_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mpt_ff        <= METERS_PER_TICK_RESET;
         hpt_ff        <= HEADING_PER_TICK_RESET;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         yaw_ff        <= '0;
         sat_ff        <= 1'b0;
         iter_ff       <= '0;
      end else begin
         mpt_ff        <= mpt_in;
         hpt_ff        <= hpt_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         yaw_ff        <= yaw_in;
         sat_ff        <= sat_in;
         iter_ff       <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      mag_neg_ff  <= mag_neg_in;
      dprod_ff    <= dprod_in;
      prod_neg_ff <= prod_neg_in;
      dist_mag_ff <= dist_mag_in;
      dist_neg_ff <= dist_neg_in;
      hprod_ff    <= hprod_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      flip_ff     <= flip_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      px_ff       <= px_in;
      px_neg_ff   <= px_neg_in;
      py_ff       <= py_in;
      py_neg_ff   <= py_neg_in;
   end

   assign pose_x    = pos_x_ff;
   assign pose_y    = pos_y_ff;
   assign heading   = HEADING_W'(yaw_ff);
   assign saturated = sat_ff;

endmodule

// File: rtl/core/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential drive wheel odometry with a fixed point pose and cordic heading.
// ----------------------------------------------------------------------------
// Each request beat carries the absolute left and right encoder counts; the
// block takes wrapping deltas against the previous counts, moves x and y by the
// centre distance along the cosine and sine of the old heading, then turns the
// heading by the scaled count difference. One pose beat follows each request,
// after 16 iterations of a single shift-add cordic stage, a step to round sine
// and cosine, the scaling of x then y on one shared multiplier and a commit
// step. The pose beat sits in the output registers while the next request is
// taken; no request is taken until the commit step of the last one, and a pose
// beat still waiting holds that commit step. Register writes are taken in any
// cycle and should only be made while no update is in flight. No memory, so
// no start-up sweep after reset.
// ----------------------------------------------------------------------------
module diff_drive_odometry
   import ddo_pkg::*;
#(
   parameter int COUNT_BITS     = 32,
   parameter int ANGLE_BITS     = 16,
   parameter int POSE_FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ddo_req_if.sink   req_ch,
   ddo_rsp_if.source rsp_ch,
   ddo_csr_if.sink   csr_ch
);

   ddo_cmd_type    cmd;
   ddo_status_type status;

   assign csr_ch.ready = 1'b1;

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ddo_dpath #(
      .COUNT_BITS     (COUNT_BITS),
      .ANGLE_BITS     (ANGLE_BITS),
      .POSE_FRAC_BITS (POSE_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .left_count  (req_ch.left_count),
      .right_count (req_ch.right_count),
      .csr_write   (csr_ch.valid & csr_ch.ready),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .pose_x      (rsp_ch.pose_x),
      .pose_y      (rsp_ch.pose_y),
      .heading     (rsp_ch.heading),
      .saturated   (rsp_ch.saturated)
   );

endmodule
